// File: hdl/buffered_delta_network_step_unit_assert.svh
// Assertion macros for the delta network step unit.
// BDN_ASSERT_IMPL: same-cycle implication. BDN_ASSERT_NEXT: next-cycle implication.
`ifndef BUFFERED_DELTA_NETWORK_STEP_UNIT_ASSERT_SVH
`define BUFFERED_DELTA_NETWORK_STEP_UNIT_ASSERT_SVH

`ifndef SYNTH
`define BDN_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BDN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BDN_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define BDN_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: hdl/bdn_pkg.sv
`timescale 1ns / 1ps

package bdn_pkg;

   localparam int STAGES      = 3;
   localparam int PORTS       = 8;
   localparam int DELAY_BITS  = 16;

   localparam int PORT_BITS   = $clog2(PORTS);
   localparam int STAGE_BITS  = $clog2(STAGES);
   localparam int DEST_BITS   = STAGES;
   localparam int COUNT_BITS  = 4;
   localparam int SUM_BITS    = 19;
   localparam int MASK_BITS   = 8;
   localparam int DESTS_BITS  = 24;
   localparam int ARB_BITS    = 16;

   localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

   typedef struct packed {
      logic                  valid;
      logic [PORT_BITS-1:0]  source;
      logic [DEST_BITS-1:0]  dest;
      logic [DELAY_BITS-1:0] delay;
   } slot_type;

   // one routing lane's verdict: did a packet move, and from which source slot
   typedef struct packed {
      logic             moved;
      logic [PORTS-1:0] take;
   } hop_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] accepted;
      logic [COUNT_BITS-1:0] blocked;
      logic [COUNT_BITS-1:0] departed;
      logic [SUM_BITS-1:0]   delay_sum;
   } result_type;

   // target slot in the next stage: low bits from the source, high bits from the destination
   function automatic logic [PORT_BITS-1:0] route(input logic [STAGE_BITS-1:0] stage,
                                                  input logic [PORT_BITS-1:0]  src,
                                                  input logic [DEST_BITS-1:0]  dst);
      logic [DEST_BITS-1:0] keep;
      logic [PORT_BITS-1:0] lo;
      logic [DEST_BITS-1:0] hi;
      keep = DEST_BITS'(STAGES - 1) - DEST_BITS'(stage);
      lo   = src >> (stage + 1'b1);
      hi   = (dst >> keep) << keep;
      return lo | PORT_BITS'(hi);
   endfunction

endpackage

// File: hdl/bdn_route_lane.sv
`timescale 1ns / 1ps

// One target slot of one stage boundary: finds contenders, arbitrates, moves.
module bdn_route_lane (
   input  logic [bdn_pkg::STAGE_BITS-1:0]           stage_idx,
   input  logic [bdn_pkg::PORT_BITS-1:0]            target_idx,
   input  logic                                     arb_bit,
   input  bdn_pkg::slot_type                        target_slot,
   input  bdn_pkg::slot_type [bdn_pkg::PORTS-1:0]   src_slots,
   output bdn_pkg::slot_type                        next_slot,
   output bdn_pkg::hop_type                         hop
);

   logic [bdn_pkg::PORTS-1:0]     contend;
   logic [bdn_pkg::PORT_BITS-1:0] first_idx;
   logic [bdn_pkg::PORT_BITS-1:0] last_idx;
   logic [bdn_pkg::PORT_BITS-1:0] winner;
   logic                          found;

   always_comb begin
      found     = 1'b0;
      first_idx = '0;
      last_idx  = '0;
      for (int j = 0; j < bdn_pkg::PORTS; j++) begin
         contend[j] = src_slots[j].valid &&
                      (bdn_pkg::route(stage_idx, src_slots[j].source, src_slots[j].dest)
                       == target_idx);
         if (contend[j]) begin
            if (!found) begin
               first_idx = bdn_pkg::PORT_BITS'(j);
            end
            found    = 1'b1;
            last_idx = bdn_pkg::PORT_BITS'(j);
         end
      end
      winner    = (arb_bit && (last_idx != first_idx)) ? last_idx : first_idx;
      hop.moved = found && !target_slot.valid;
      hop.take  = hop.moved ? (bdn_pkg::PORTS'(1) << winner) : '0;
      next_slot = hop.moved ? src_slots[winner] : target_slot;
   end

endmodule

// File: hdl/bdn_tally.sv
`timescale 1ns / 1ps

// Merges the lanes' outcomes into the tick's counts and departure delay sum.
module bdn_tally (
   input  bdn_pkg::slot_type [bdn_pkg::PORTS-1:0] depart_slots,
   input  logic [bdn_pkg::PORTS-1:0]              arrivals,
   input  logic [bdn_pkg::PORTS-1:0]              occupied,
   output bdn_pkg::result_type                    result
);

   always_comb begin
      result = '0;
      for (int j = 0; j < bdn_pkg::PORTS; j++) begin
         if (arrivals[j] && occupied[j]) begin
            result.blocked = result.blocked + 1'b1;
         end
         if (arrivals[j] && !occupied[j]) begin
            result.accepted = result.accepted + 1'b1;
         end
         if (depart_slots[j].valid) begin
            result.departed  = result.departed + 1'b1;
            result.delay_sum = result.delay_sum
                             + bdn_pkg::SUM_BITS'(depart_slots[j].delay);
         end
      end
   end

endmodule

// File: hdl/buffered_delta_network_step_unit.sv
`timescale 1ns / 1ps
// Delta network step unit: each accepted request word advances a three-stage,
// eight-port single-buffered switch fabric by one tick and yields one response
// word with the tick's accepted, blocked and departed counts and the summed
// delay of the departing packets. One word is taken per clock; its response
// appears in the output register on the next cycle. The rate is set by the
// fabric state register: the whole tick (aging, departures, back-to-front hops
// through one routing lane per target slot, arrivals) settles combinationally,
// and the next tick starts from the state it leaves. A request is held off
// only while a finished response sits unclaimed under rsp_stall.
`include "buffered_delta_network_step_unit_assert.svh"

module buffered_delta_network_step_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bdn_pkg::MASK_BITS-1:0]      req_arrival_mask,
   input  logic [bdn_pkg::DESTS_BITS-1:0]     req_arrival_dests,
   input  logic [bdn_pkg::ARB_BITS-1:0]       req_arbitration_bits,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bdn_pkg::COUNT_BITS-1:0]     rsp_accepted_count,
   output logic [bdn_pkg::COUNT_BITS-1:0]     rsp_blocked_count,
   output logic [bdn_pkg::COUNT_BITS-1:0]     rsp_departed_count,
   output logic [bdn_pkg::SUM_BITS-1:0]       rsp_delay_sum
);

   localparam int LAST = bdn_pkg::STAGES - 1;

   // fabric state, one row of slots per stage
   bdn_pkg::slot_type [bdn_pkg::PORTS-1:0] state_ff [bdn_pkg::STAGES];
   bdn_pkg::slot_type [bdn_pkg::PORTS-1:0] state_in [bdn_pkg::STAGES];
   // after delay aging
   bdn_pkg::slot_type [bdn_pkg::PORTS-1:0] aged     [bdn_pkg::STAGES];
   // after outgoing hops (or departures, for the last stage)
   bdn_pkg::slot_type [bdn_pkg::PORTS-1:0] vacated  [bdn_pkg::STAGES];
   // after incoming hops (or arrivals, for stage 0)
   bdn_pkg::slot_type [bdn_pkg::PORTS-1:0] filled   [bdn_pkg::STAGES];

   bdn_pkg::hop_type hop [bdn_pkg::STAGES-1][bdn_pkg::PORTS];

   logic [bdn_pkg::PORTS-1:0] arrivals;
   logic [bdn_pkg::PORTS-1:0] occupied;
   bdn_pkg::result_type       result;
   logic                      req_fire;

   logic                              rsp_valid_ff;
   logic [bdn_pkg::COUNT_BITS-1:0]    accepted_ff;
   logic [bdn_pkg::COUNT_BITS-1:0]    blocked_ff;
   logic [bdn_pkg::COUNT_BITS-1:0]    departed_ff;
   logic [bdn_pkg::SUM_BITS-1:0]      delay_sum_ff;

   // output register frees up on the same edge it is drained
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   // aging: every held packet's delay +1, saturating
   always_comb begin
      for (int s = 0; s < bdn_pkg::STAGES; s++) begin
         for (int p = 0; p < bdn_pkg::PORTS; p++) begin
            aged[s][p] = state_ff[s][p];
            if (state_ff[s][p].valid && (state_ff[s][p].delay != bdn_pkg::DELAY_MAX)) begin
               aged[s][p].delay = state_ff[s][p].delay + 1'b1;
            end
         end
      end
   end

   // per-stage vacate logic; kept per stage so the back-to-front chain has no false loop
   for (genvar s = 0; s < bdn_pkg::STAGES; s++) begin : g_vacate
      if (s == LAST) begin : g_depart
         always_comb begin
            vacated[s] = aged[s];
            for (int p = 0; p < bdn_pkg::PORTS; p++) begin
               vacated[s][p].valid = 1'b0;
            end
         end
      end else begin : g_hop_out
         always_comb begin
            logic taken;
            vacated[s] = aged[s];
            for (int p = 0; p < bdn_pkg::PORTS; p++) begin
               taken = 1'b0;
               for (int t = 0; t < bdn_pkg::PORTS; t++) begin
                  taken = taken | hop[s][t].take[p];
               end
               vacated[s][p].valid = aged[s][p].valid && !taken;
            end
         end
      end
   end

   // routing lanes: boundary b moves stage b packets into stage b+1
   for (genvar b = 0; b < bdn_pkg::STAGES - 1; b++) begin : g_boundary
      for (genvar t = 0; t < bdn_pkg::PORTS; t++) begin : g_lane
         bdn_route_lane u_lane (
            .stage_idx   (bdn_pkg::STAGE_BITS'(b)),
            .target_idx  (bdn_pkg::PORT_BITS'(t)),
            .arb_bit     (req_arbitration_bits[b * bdn_pkg::PORTS + t]),
            .target_slot (vacated[b+1][t]),
            .src_slots   (aged[b]),
            .next_slot   (filled[b+1][t]),
            .hop         (hop[b][t])
         );
      end
   end

   // arrivals enter stage 0 at their own port if the slot is free
   always_comb begin
      filled[0] = vacated[0];
      for (int p = 0; p < bdn_pkg::PORTS; p++) begin
         arrivals[p] = req_arrival_mask[p];
         occupied[p] = vacated[0][p].valid;
         if (arrivals[p] && !occupied[p]) begin
            filled[0][p].valid  = 1'b1;
            filled[0][p].source = bdn_pkg::PORT_BITS'(p);
            filled[0][p].dest   = req_arrival_dests[p * bdn_pkg::DEST_BITS +: bdn_pkg::DEST_BITS];
            filled[0][p].delay  = '0;
         end
      end
   end

   bdn_tally u_tally (
      .depart_slots (aged[LAST]),
      .arrivals     (arrivals),
      .occupied     (occupied),
      .result       (result)
   );

   always_comb begin
      for (int s = 0; s < bdn_pkg::STAGES; s++) begin
         state_in[s] = req_fire ? filled[s] : state_ff[s];
      end
   end

   // reset empties every slot and zeroes its fields
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < bdn_pkg::STAGES; s++) begin
            state_ff[s] <= '0;
         end
      end else begin
         for (int s = 0; s < bdn_pkg::STAGES; s++) begin
            state_ff[s] <= state_in[s];
         end
      end
   end

   // response word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (req_fire) begin
         accepted_ff  <= result.accepted;
         blocked_ff   <= result.blocked;
         departed_ff  <= result.departed;
         delay_sum_ff <= result.delay_sum;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted_count = accepted_ff;
   assign rsp_blocked_count  = blocked_ff;
   assign rsp_departed_count = departed_ff;
   assign rsp_delay_sum      = delay_sum_ff;

   `BDN_ASSERT_NEXT(a_fire_loads_word, clock, reset, req_fire, rsp_valid)
   `BDN_ASSERT_IMPL(a_full_holds_req, clock, reset, rsp_valid && rsp_stall, req_stall)
   `BDN_ASSERT_IMPL(a_sum_needs_departure, clock, reset, rsp_valid && (rsp_departed_count == '0), rsp_delay_sum == '0)
   `BDN_ASSERT_IMPL(a_arrivals_bounded, clock, reset, rsp_valid, (rsp_accepted_count + rsp_blocked_count) <= bdn_pkg::PORTS)

endmodule
